/* hw/rtl/pets_pkg.sv */
// package for the priority event task scheduler
// payload types, command and error codes; no dependencies
package pets_pkg;

    localparam int TaskSlotsDef   = 8;
    localparam int TriggerBitsDef = 8;

    typedef enum logic [3:0] {
        OP_CREATE    = 4'd0,
        OP_SET_PRIO  = 4'd1,
        OP_OVERRIDE  = 4'd2,
        OP_RESTORE   = 4'd3,
        OP_GET_CUR   = 4'd4,
        OP_GET_NAT   = 4'd5,
        OP_WAIT      = 4'd6,
        OP_SET_TRIG  = 4'd7,
        OP_CLR_TRIG  = 4'd8,
        OP_POLL      = 4'd9,
        OP_SEND      = 4'd10,
        OP_SEND_NOSW = 4'd11,
        OP_START     = 4'd12
    } t_op;

    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_RANGE       = 3'd1,
        ERR_NO_SLOT     = 3'd2,
        ERR_NO_READY    = 3'd3,
        ERR_NOT_STARTED = 3'd4,
        ERR_NOT_CREATED = 3'd5
    } t_err;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] task_id;
        logic [7:0] priority_req;
        logic [7:0] trigger_mask;
    } t_cmd;

    typedef struct packed {
        logic [7:0] result_task;
        logic [7:0] result_value;
        logic       switched;
        logic [2:0] error_code;
    } t_rsp;

endpackage

/* hw/rtl/priority_event_task_scheduler.sv */
// top level of the priority event task scheduler: task table and sequencer
// depends on pets_pkg and pets_list
//
// Usage: one command channel (i_cmd_valid / o_cmd_stall, payload i_cmd) and
// one response channel (o_rsp_valid / i_rsp_stall, payload o_rsp). Every
// command gives exactly one response. A command is taken only while the block
// is idle; a list pass then walks the ready list one entry per cycle through
// the list memory port. Simple commands need no list pass; a create or a
// reschedule makes an insert pass or a pick pass, and a priority move makes a
// remove pass and then an insert pass. The response is held in an output
// register until taken; while i_rsp_stall is high the block stays busy and
// takes no new command. Reset clears the created flags, list length, slot
// counter, running task and started flag; no clearing pass is needed. A new
// command is taken only after the response to the last one has been taken.
module priority_event_task_scheduler
    import pets_pkg::*;
#(
    parameter int TASK_SLOTS   = TaskSlotsDef,
    parameter int TRIGGER_BITS = TriggerBitsDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    output logic o_cmd_stall,
    input  t_cmd i_cmd,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);
    localparam int TW = $clog2(TASK_SLOTS);
    localparam int LW = $clog2(TASK_SLOTS + 1);
    localparam int MW = (TRIGGER_BITS < 8) ? TRIGGER_BITS : 8;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_REM, S_INS_SCAN, S_INS_SHIFT, S_PICK, S_RESP
    } t_state;

    t_state          r_state;
    t_cmd            r_cmd;
    logic [TASK_SLOTS-1:0] r_created;
    logic [7:0]      r_nat [TASK_SLOTS];
    logic [7:0]      r_cur [TASK_SLOTS];
    logic [MW-1:0]   r_wait [TASK_SLOTS];
    logic [MW-1:0]   r_trig [TASK_SLOTS];
    logic [LW-1:0]   r_alloc;
    logic [TW-1:0]   r_run;
    logic            r_started;
    logic [TW-1:0]   r_tgt;
    logic [7:0]      r_newp;
    logic [LW-1:0]   r_pos;
    logic [LW-1:0]   r_ins_pos;
    logic [TW-1:0]   r_prev;
    logic            r_found;
    logic            r_pick_after;
    logic [TW-1:0]   r_old;
    logic [7:0]      r_value;
    logic [2:0]      r_err;
    logic            r_rsp_valid;
    t_rsp            r_rsp;

    logic [TW-1:0]   w_rd_task;
    logic [LW-1:0]   w_len;
    logic            w_wr_en, w_inc, w_dec;
    logic [TW-1:0]   w_wr_pos, w_wr_task, w_rd_pos;

    logic [MW-1:0]   w_mask;
    logic [TW-1:0]   w_tid;
    logic            w_tid_ok;

    assign w_mask   = r_cmd.trigger_mask[MW-1:0];
    assign w_tid    = r_cmd.task_id[TW-1:0];
    assign w_tid_ok = (32'(r_cmd.task_id) < TASK_SLOTS);

    pets_list #(.TASK_SLOTS(TASK_SLOTS)) u_list (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (1'b0),
        .i_rd_pos  (w_rd_pos),
        .o_rd_task (w_rd_task),
        .i_wr_en   (w_wr_en),
        .i_wr_pos  (w_wr_pos),
        .i_wr_task (w_wr_task),
        .i_len_inc (w_inc),
        .i_len_dec (w_dec),
        .o_len     (w_len)
    );

    // list port control
    always_comb begin
        w_rd_pos  = r_pos[TW-1:0];
        w_wr_en   = 1'b0;
        w_wr_pos  = r_pos[TW-1:0];
        w_wr_task = r_tgt;
        w_inc     = 1'b0;
        w_dec     = 1'b0;
        case (r_state)
            S_REM: begin
                if (r_pos + LW'(1) < w_len) begin
                    w_rd_pos = TW'(r_pos + LW'(1));
                    if (r_found || r_prev == r_tgt) begin
                        w_wr_en   = 1'b1;
                        w_wr_task = w_rd_task;
                    end
                end else if (r_found || r_prev == r_tgt) begin
                    w_dec = 1'b1;
                end
            end
            S_INS_SHIFT: begin
                if (r_pos > r_ins_pos) begin
                    w_rd_pos  = TW'(r_pos - LW'(1));
                    w_wr_en   = 1'b1;
                    w_wr_task = w_rd_task;
                end else begin
                    w_wr_en = 1'b1;
                    w_wr_pos = r_ins_pos[TW-1:0];
                    w_inc   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_created   <= '0;
            r_alloc     <= '0;
            r_run       <= '0;
            r_started   <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_old   <= r_run;
                        r_value <= '0;
                        r_err   <= ERR_OK;
                        r_pos   <= '0;
                        r_pick_after <= 1'b0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_pos   <= '0;
                    r_found <= 1'b0;
                    r_prev  <= w_rd_task;
                    case (t_op'(r_cmd.op))
                        OP_CREATE: begin
                            if (32'(r_alloc) >= TASK_SLOTS) begin
                                r_err   <= ERR_NO_SLOT;
                                r_state <= S_RESP;
                            end else begin
                                logic [TW-1:0] v_t;
                                v_t = (r_alloc == '0) ? TW'(TASK_SLOTS - 1)
                                                      : TW'(r_alloc - LW'(1));
                                r_alloc        <= r_alloc + LW'(1);
                                r_created[v_t] <= 1'b1;
                                r_nat[v_t]     <= r_cmd.priority_req;
                                r_cur[v_t]     <= r_cmd.priority_req;
                                r_wait[v_t]    <= '0;
                                r_trig[v_t]    <= '0;
                                r_tgt          <= v_t;
                                r_newp         <= r_cmd.priority_req;
                                r_state        <= S_INS_SCAN;
                            end
                        end
                        OP_SET_PRIO, OP_OVERRIDE, OP_RESTORE, OP_GET_CUR, OP_GET_NAT,
                        OP_SEND, OP_SEND_NOSW: begin
                            if (!w_tid_ok) begin
                                r_err   <= ERR_RANGE;
                                r_state <= S_RESP;
                            end else if (!r_created[w_tid]) begin
                                r_err   <= ERR_NOT_CREATED;
                                r_state <= S_RESP;
                            end else begin
                                r_tgt <= w_tid;
                                case (t_op'(r_cmd.op))
                                    OP_SET_PRIO: begin
                                        if (r_cur[w_tid] != r_cmd.priority_req) begin
                                            r_nat[w_tid] <= r_cmd.priority_req;
                                            r_newp  <= r_cmd.priority_req;
                                            r_state <= S_REM;
                                        end else begin
                                            r_state <= S_RESP;
                                        end
                                    end
                                    OP_OVERRIDE: begin
                                        if (r_cur[w_tid] != r_cmd.priority_req) begin
                                            r_newp  <= r_cmd.priority_req;
                                            r_state <= S_REM;
                                        end else begin
                                            r_state <= S_RESP;
                                        end
                                    end
                                    OP_RESTORE: begin
                                        if (r_cur[w_tid] != r_nat[w_tid]) begin
                                            r_newp  <= r_nat[w_tid];
                                            r_state <= S_REM;
                                        end else begin
                                            r_state <= S_RESP;
                                        end
                                    end
                                    OP_GET_CUR: begin
                                        r_value <= r_cur[w_tid];
                                        r_state <= S_RESP;
                                    end
                                    OP_GET_NAT: begin
                                        r_value <= r_nat[w_tid];
                                        r_state <= S_RESP;
                                    end
                                    OP_SEND: begin
                                        r_trig[w_tid] <= r_trig[w_tid] | w_mask;
                                        if (r_started && (r_wait[w_tid] & w_mask) != '0)
                                            r_state <= S_PICK;
                                        else
                                            r_state <= S_RESP;
                                    end
                                    default: begin
                                        r_trig[w_tid] <= r_trig[w_tid] | w_mask;
                                        r_state       <= S_RESP;
                                    end
                                endcase
                            end
                        end
                        OP_WAIT, OP_SET_TRIG, OP_CLR_TRIG, OP_POLL: begin
                            if (!r_started) begin
                                r_err   <= ERR_NOT_STARTED;
                                r_state <= S_RESP;
                            end else begin
                                case (t_op'(r_cmd.op))
                                    OP_WAIT: begin
                                        if ((w_mask & r_trig[r_run]) != '0) begin
                                            r_value <= w_mask & r_trig[r_run];
                                            r_trig[r_run] <= r_trig[r_run] & ~w_mask;
                                            r_wait[r_run] <= '0;
                                            r_state <= S_RESP;
                                        end else begin
                                            r_wait[r_run] <= w_mask;
                                            r_state <= S_PICK;
                                        end
                                    end
                                    OP_SET_TRIG: begin
                                        r_trig[r_run] <= r_trig[r_run] | w_mask;
                                        r_state       <= S_RESP;
                                    end
                                    OP_CLR_TRIG: begin
                                        r_trig[r_run] <= r_trig[r_run] & ~w_mask;
                                        r_state       <= S_RESP;
                                    end
                                    default: begin
                                        r_value <= 8'(w_mask & r_trig[r_run]);
                                        r_state <= S_RESP;
                                    end
                                endcase
                            end
                        end
                        OP_START: begin
                            if (!r_started) begin
                                if (w_len == '0) begin
                                    r_err <= ERR_NO_READY;
                                end else begin
                                    r_started <= 1'b1;
                                    r_run     <= w_rd_task;
                                    r_old     <= ~w_rd_task;
                                end
                            end
                            r_state <= S_RESP;
                        end
                        default: r_state <= S_RESP;
                    endcase
                end
                S_REM: begin
                    r_prev <= w_rd_task;
                    if (r_prev == r_tgt) r_found <= 1'b1;
                    if (r_pos + LW'(1) < w_len) begin
                        r_pos <= r_pos + LW'(1);
                    end else begin
                        r_cur[r_tgt] <= r_newp;
                        r_pos   <= '0;
                        r_state <= S_INS_SCAN;
                    end
                end
                S_INS_SCAN: begin
                    if (32'(w_len) >= TASK_SLOTS) begin
                        r_state <= S_RESP;
                    end else if (r_pos < w_len && r_cur[w_rd_task] >= r_newp) begin
                        r_pos <= r_pos + LW'(1);
                    end else begin
                        r_ins_pos <= r_pos;
                        r_pos     <= w_len;
                        r_state   <= S_INS_SHIFT;
                    end
                end
                S_INS_SHIFT: begin
                    if (r_pos > r_ins_pos) begin
                        r_pos <= r_pos - LW'(1);
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_PICK: begin
                    if (r_pos >= w_len) begin
                        r_err   <= ERR_NO_READY;
                        r_state <= S_RESP;
                    end else if (r_wait[w_rd_task] == '0
                                 || (r_wait[w_rd_task] & r_trig[w_rd_task]) != '0) begin
                        r_value <= 8'(r_wait[w_rd_task] & r_trig[w_rd_task]);
                        r_trig[w_rd_task] <= r_trig[w_rd_task] & ~r_wait[w_rd_task];
                        r_wait[w_rd_task] <= '0;
                        r_run   <= w_rd_task;
                        r_state <= S_RESP;
                    end else begin
                        r_pos <= r_pos + LW'(1);
                    end
                end
                S_RESP: begin
                    if (!r_rsp_valid) begin
                        r_rsp_valid <= 1'b1;
                        r_rsp.result_task  <= 8'(((t_op'(r_cmd.op) == OP_CREATE)
                                               && r_err == ERR_OK) ? r_tgt : r_run);
                        r_rsp.result_value <= ((t_op'(r_cmd.op) == OP_CREATE)) ? '0 : r_value;
                        r_rsp.switched     <= (t_op'(r_cmd.op) != OP_CREATE
                                               || r_err != ERR_OK) && (r_run != r_old);
                        r_rsp.error_code   <= (t_op'(r_cmd.op) == OP_CREATE
                                               && r_err == ERR_OK) ? ERR_OK : r_err;
                    end else if (!i_rsp_stall) begin
                        r_rsp_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
endmodule

/* hw/rtl/pets_list.sv */
// ready list of the scheduler: one entry is visited per cycle
// depends on pets_pkg
module pets_list
    import pets_pkg::*;
#(
    parameter int TASK_SLOTS = TaskSlotsDef,
    localparam int TW = $clog2(TASK_SLOTS),
    localparam int LW = $clog2(TASK_SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic [TW-1:0] i_rd_pos,
    output logic [TW-1:0] o_rd_task,
    input  logic          i_wr_en,
    input  logic [TW-1:0] i_wr_pos,
    input  logic [TW-1:0] i_wr_task,
    input  logic          i_len_inc,
    input  logic          i_len_dec,
    output logic [LW-1:0] o_len
);
    logic [TW-1:0] r_order [TASK_SLOTS];
    logic [LW-1:0] r_len;

    assign o_rd_task = r_order[i_rd_pos];
    assign o_len     = r_len;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_order[i_wr_pos] <= i_wr_task;
        end
        if (!i_rst_n || i_clr) begin
            r_len <= '0;
        end else if (i_len_inc) begin
            r_len <= r_len + LW'(1);
        end else if (i_len_dec) begin
            r_len <= r_len - LW'(1);
        end
    end
endmodule

/* hw/rtl/pets_checker.sv */
// port-level checker for the priority event task scheduler
// depends on pets_pkg; bound to priority_event_task_scheduler
module pets_checker
    import pets_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cmd_valid,
    input logic o_cmd_stall,
    input logic o_rsp_valid,
    input logic i_rsp_stall,
    input t_rsp o_rsp
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");
    a_busy_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_cmd_stall)
        else $error("command taken while response pending");
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !o_cmd_stall |=> o_cmd_stall)
        else $error("block not busy after command transfer");
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.error_code <= ERR_NOT_CREATED)
        else $error("bad error code");
endmodule

bind priority_event_task_scheduler pets_checker u_pets_checker (.*);
